@@ rtl/core/matf_pkg.sv @@
// Shared types and constants for the motion adaptive temporal filter.
package matf_pkg;

  localparam int unsigned FractionBits = 16;
  localparam int unsigned PixW         = 8;
  localparam int unsigned ThrW         = 9;
  localparam int unsigned DistW        = 18;
  localparam int unsigned SqW          = 2 * ThrW;
  localparam int unsigned RootW        = FractionBits + 9;
  localparam int unsigned RemW         = FractionBits + 12;
  localparam int unsigned SqrtSteps    = FractionBits + 9;
  localparam int unsigned DivSteps     = FractionBits;
  localparam int unsigned DivRemW      = ThrW + 1;
  localparam int unsigned MixW         = FractionBits + PixW + 1;
  localparam int unsigned QDepth       = 4;
  localparam int unsigned QPtrW        = 2;
  localparam int unsigned QCntW        = 3;
  localparam int unsigned CfgIdxW      = 8;
  localparam int unsigned CfgDataW     = 16;

  localparam logic [CfgIdxW-1:0] RegLow  = CfgIdxW'(0);
  localparam logic [CfgIdxW-1:0] RegHigh = CfgIdxW'(1);

  typedef enum logic [1:0] {
    DEC_KEEP    = 2'd0,
    DEC_BLEND   = 2'd1,
    DEC_REPLACE = 2'd2
  } dec_e;

  typedef logic [2:0][PixW-1:0] rgb_t;

  typedef struct packed {
    rgb_t             cur;
    rgb_t             prev;
    logic [DistW-1:0] sq_dist;
    dec_e             dec;
  } item_t;

  typedef struct packed {
    logic [ThrW-1:0] low;
    logic [ThrW-1:0] high;
    logic [SqW-1:0]  low_sq;
    logic [SqW-1:0]  high_sq;
  } cfg_t;

endpackage

@@ rtl/core/matf_cfg.sv @@
// Threshold registers and their squares, computed when written.
module matf_cfg (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_valid_i,
  input  logic [matf_pkg::CfgIdxW-1:0]      cfg_index_i,
  input  logic [matf_pkg::CfgDataW-1:0]     cfg_data_i,
  output matf_pkg::cfg_t                    cfg_o
);

  logic [matf_pkg::ThrW-1:0] wdata;
  logic [matf_pkg::SqW-1:0]  wsq;
  matf_pkg::cfg_t            cfg_q, cfg_d;

  assign wdata = cfg_data_i[matf_pkg::ThrW-1:0];
  assign wsq   = matf_pkg::SqW'(wdata) * matf_pkg::SqW'(wdata);

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      unique case (cfg_index_i)
        matf_pkg::RegLow: begin
          cfg_d.low    = wdata;
          cfg_d.low_sq = wsq;
        end
        matf_pkg::RegHigh: begin
          cfg_d.high    = wdata;
          cfg_d.high_sq = wsq;
        end
        default: cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

@@ rtl/core/matf_front.sv @@
// Front end: forms the squared colour distance and classifies the pixel.
module matf_front (
  input  matf_pkg::rgb_t  cur_i,
  input  matf_pkg::rgb_t  prev_i,
  input  matf_pkg::cfg_t  cfg_i,
  output matf_pkg::item_t item_o
);

  logic [matf_pkg::PixW:0]    diff [3];
  logic [matf_pkg::PixW-1:0]  mag  [3];
  logic [2*matf_pkg::PixW-1:0] sq  [3];
  logic [matf_pkg::DistW-1:0] sq_dist;

  always_comb begin
    sq_dist = '0;
    for (int b = 0; b < 3; b++) begin
      diff[b] = {1'b0, cur_i[b]} - {1'b0, prev_i[b]};
      mag[b]  = diff[b][matf_pkg::PixW] ? matf_pkg::PixW'(-diff[b])
                                        : diff[b][matf_pkg::PixW-1:0];
      sq[b]   = (2*matf_pkg::PixW)'(mag[b]) * (2*matf_pkg::PixW)'(mag[b]);
      sq_dist = sq_dist + matf_pkg::DistW'(sq[b]);
    end
  end

  always_comb begin
    item_o.cur     = cur_i;
    item_o.prev    = prev_i;
    item_o.sq_dist = sq_dist;
    if (sq_dist < cfg_i.low_sq) begin
      item_o.dec = matf_pkg::DEC_KEEP;
    end else if (sq_dist < cfg_i.high_sq) begin
      item_o.dec = matf_pkg::DEC_BLEND;
    end else begin
      item_o.dec = matf_pkg::DEC_REPLACE;
    end
  end

endmodule

@@ rtl/core/matf_queue.sv @@
// Short queue of classified pixels between the front and back ends.
module matf_queue (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  matf_pkg::item_t item_i,
  output logic            full_o,
  input  logic            pop_i,
  output logic            empty_o,
  output matf_pkg::item_t item_o
);

  matf_pkg::item_t                mem_q [matf_pkg::QDepth];
  logic [matf_pkg::QPtrW-1:0]     wr_q, rd_q;
  logic [matf_pkg::QCntW-1:0]     cnt_q;
  logic                           do_push, do_pop;

  assign full_o  = (cnt_q == matf_pkg::QCntW'(matf_pkg::QDepth));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i & ~full_o;
  assign do_pop  = pop_i & ~empty_o;
  assign item_o  = mem_q[rd_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) wr_q <= wr_q + 1'b1;
      if (do_pop) rd_q <= rd_q + 1'b1;
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wr_q] <= item_i;
  end

endmodule

@@ rtl/core/matf_back.sv @@
// Back end: pipelined square root, pipelined division and the blend stage.
module matf_back (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  matf_pkg::cfg_t        cfg_i,
  input  logic                  q_empty_i,
  input  matf_pkg::item_t       q_item_i,
  output logic                  q_pop_o,
  input  logic                  pop_i,
  output logic                  empty_o,
  output matf_pkg::rgb_t        out_o,
  output matf_pkg::rgb_t        new_prev_o,
  output matf_pkg::dec_e        dec_o
);

  localparam int unsigned F = matf_pkg::FractionBits;

  logic adv;

  // Square root stages, one root bit each.
  logic                          sq_vld_q  [matf_pkg::SqrtSteps];
  matf_pkg::item_t               sq_item_q [matf_pkg::SqrtSteps];
  logic [matf_pkg::RootW-1:0]    sq_root_q [matf_pkg::SqrtSteps];
  logic [matf_pkg::RemW-1:0]     sq_rem_q  [matf_pkg::SqrtSteps];

  // Division stages, one quotient bit each.
  logic                          dv_vld_q  [matf_pkg::DivSteps];
  matf_pkg::item_t               dv_item_q [matf_pkg::DivSteps];
  logic [matf_pkg::DivRemW-1:0]  dv_rem_q  [matf_pkg::DivSteps];
  logic [F-1:0]                  dv_bits_q [matf_pkg::DivSteps];
  logic [F-1:0]                  dv_quo_q  [matf_pkg::DivSteps];

  logic                          out_vld_q;
  matf_pkg::rgb_t                out_q, np_q;
  matf_pkg::dec_e                dec_q;

  logic [matf_pkg::ThrW-1:0]     delta;

  assign adv     = ~out_vld_q | pop_i;
  assign q_pop_o = adv & ~q_empty_i;
  assign delta   = cfg_i.high - cfg_i.low;

  for (genvar j = 0; j < matf_pkg::SqrtSteps; j++) begin : g_sqrt
    localparam int I = 8 - j;
    logic                       vld_in;
    matf_pkg::item_t            item_in;
    logic [matf_pkg::RootW-1:0] root_in;
    logic [matf_pkg::RemW-1:0]  rem_in, rem_sh, trial;
    logic [1:0]                 pair;
    logic                       ge;

    if (j == 0) begin : g_first
      assign vld_in  = q_pop_o;
      assign item_in = q_item_i;
      assign root_in = '0;
      assign rem_in  = '0;
    end else begin : g_next
      assign vld_in  = sq_vld_q[j-1];
      assign item_in = sq_item_q[j-1];
      assign root_in = sq_root_q[j-1];
      assign rem_in  = sq_rem_q[j-1];
    end

    if (I >= 0) begin : g_pair
      assign pair = item_in.sq_dist[2*I+1 -: 2];
    end else begin : g_zero
      assign pair = 2'b00;
    end

    assign rem_sh = {rem_in[matf_pkg::RemW-3:0], pair};
    assign trial  = matf_pkg::RemW'({root_in, 2'b01});
    assign ge     = (rem_sh >= trial);

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        sq_vld_q[j] <= 1'b0;
      end else if (adv) begin
        sq_vld_q[j] <= vld_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (adv) begin
        sq_item_q[j] <= item_in;
        sq_root_q[j] <= {root_in[matf_pkg::RootW-2:0], ge};
        sq_rem_q[j]  <= ge ? (rem_sh - trial) : rem_sh;
      end
    end
  end

  for (genvar k = 0; k < matf_pkg::DivSteps; k++) begin : g_div
    logic                         vld_in;
    matf_pkg::item_t              item_in;
    logic [matf_pkg::DivRemW-1:0] rem_in, r2;
    logic [F-1:0]                 bits_in, quo_in;
    logic                         ge;

    if (k == 0) begin : g_first
      logic [matf_pkg::RootW-1:0] s, base, num;
      assign s       = sq_root_q[matf_pkg::SqrtSteps-1];
      assign base    = {cfg_i.low, {F{1'b0}}};
      assign num     = (s > base) ? (s - base) : '0;
      assign vld_in  = sq_vld_q[matf_pkg::SqrtSteps-1];
      assign item_in = sq_item_q[matf_pkg::SqrtSteps-1];
      assign rem_in  = matf_pkg::DivRemW'(num[matf_pkg::RootW-1:F]);
      assign bits_in = num[F-1:0];
      assign quo_in  = '0;
    end else begin : g_next
      assign vld_in  = dv_vld_q[k-1];
      assign item_in = dv_item_q[k-1];
      assign rem_in  = dv_rem_q[k-1];
      assign bits_in = dv_bits_q[k-1];
      assign quo_in  = dv_quo_q[k-1];
    end

    assign r2 = {rem_in[matf_pkg::DivRemW-2:0], bits_in[F-1]};
    assign ge = (r2 >= matf_pkg::DivRemW'(delta));

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        dv_vld_q[k] <= 1'b0;
      end else if (adv) begin
        dv_vld_q[k] <= vld_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (adv) begin
        dv_item_q[k] <= item_in;
        dv_rem_q[k]  <= ge ? (r2 - matf_pkg::DivRemW'(delta)) : r2;
        dv_bits_q[k] <= {bits_in[F-2:0], 1'b0};
        dv_quo_q[k]  <= {quo_in[F-2:0], ge};
      end
    end
  end

  // Blend and select stage; this is also the result register.
  matf_pkg::item_t             fin;
  logic [F-1:0]                t;
  logic [F:0]                  one_minus_t;
  logic [matf_pkg::MixW-1:0]   mix [3];
  logic [matf_pkg::PixW+1:0]   avg [3];
  matf_pkg::rgb_t              out_d, np_d;

  assign fin         = dv_item_q[matf_pkg::DivSteps-1];
  assign t           = dv_quo_q[matf_pkg::DivSteps-1];
  assign one_minus_t = {1'b1, {F{1'b0}}} - (F+1)'(t);

  always_comb begin
    for (int b = 0; b < 3; b++) begin
      mix[b] = matf_pkg::MixW'(t) * matf_pkg::MixW'(fin.cur[b])
             + matf_pkg::MixW'(one_minus_t) * matf_pkg::MixW'(fin.prev[b])
             + matf_pkg::MixW'({1'b1, {(F-1){1'b0}}});
      avg[b] = 10'(fin.prev[b]) + 10'(fin.prev[b]) + 10'(fin.prev[b])
             + 10'(fin.cur[b]) + 10'd2;
      case (fin.dec)
        matf_pkg::DEC_KEEP: begin
          out_d[b] = fin.prev[b];
          np_d[b]  = fin.prev[b];
        end
        matf_pkg::DEC_BLEND: begin
          out_d[b] = mix[b][F+matf_pkg::PixW-1:F];
          np_d[b]  = avg[b][matf_pkg::PixW+1:2];
        end
        default: begin
          out_d[b] = fin.cur[b];
          np_d[b]  = fin.cur[b];
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (adv) begin
      out_vld_q <= dv_vld_q[matf_pkg::DivSteps-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_q <= out_d;
      np_q  <= np_d;
      dec_q <= fin.dec;
    end
  end

  assign empty_o    = ~out_vld_q;
  assign out_o      = out_q;
  assign new_prev_o = np_q;
  assign dec_o      = dec_q;

`ifndef SYNTHESIS
  a_keep_same : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q && dec_q == matf_pkg::DEC_KEEP |-> out_q == np_q)
    else $error("kept pixel differs from write-back value");

  a_replace_same : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q && dec_q == matf_pkg::DEC_REPLACE |-> out_q == np_q)
    else $error("replaced pixel differs from write-back value");

  a_pop_enters : assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop_o |=> sq_vld_q[0])
    else $error("queue pop did not enter the root pipeline");

  a_stall_holds : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !adv |=> $stable(sq_root_q[matf_pkg::SqrtSteps-1]) && $stable(dv_quo_q[0]))
    else $error("pipeline moved during a stall");
`endif

endmodule

@@ rtl/core/rgb_motion_adaptive_temporal_filter.sv @@
// Top level of the motion adaptive temporal noise filter for RGB pixels.
//
//   channel   direction  handshake           payload
//   input     in         push_i / full_o     cur_*_i, prev_*_i
//   result    out        pop_i / empty_o     out_*_o, new_prev_*_o, decision_o
//   config    in         cfg_valid_i/ready   cfg_index_i, cfg_data_i
//
// One pixel enters per clock while full_o is low; with F = 16 a result passes
// 25 square root digit stages, 16 quotient bit stages and one blend stage.
// A four-entry queue sits between classification and the back pipeline.
// When a result waits unpopped the whole back pipeline holds; the queue then
// fills and full_o rises. Reset clears the thresholds and all valid flags.
module rgb_motion_adaptive_temporal_filter (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          push_i,
  output logic                          full_o,
  input  logic [7:0]                    cur_red_i,
  input  logic [7:0]                    cur_green_i,
  input  logic [7:0]                    cur_blue_i,
  input  logic [7:0]                    prev_red_i,
  input  logic [7:0]                    prev_green_i,
  input  logic [7:0]                    prev_blue_i,
  output logic                          empty_o,
  input  logic                          pop_i,
  output logic [7:0]                    out_red_o,
  output logic [7:0]                    out_green_o,
  output logic [7:0]                    out_blue_o,
  output logic [7:0]                    new_prev_red_o,
  output logic [7:0]                    new_prev_green_o,
  output logic [7:0]                    new_prev_blue_o,
  output logic [1:0]                    decision_o,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [matf_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [matf_pkg::CfgDataW-1:0] cfg_data_i
);

  matf_pkg::cfg_t  cfg;
  matf_pkg::rgb_t  cur, prev, res, np;
  matf_pkg::item_t f_item, q_item;
  matf_pkg::dec_e  dec;
  logic            q_empty, q_pop;

  assign cfg_ready_o = 1'b1;
  assign cur  = {cur_blue_i, cur_green_i, cur_red_i};
  assign prev = {prev_blue_i, prev_green_i, prev_red_i};

  matf_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  matf_front u_front (
    .cur_i  (cur),
    .prev_i (prev),
    .cfg_i  (cfg),
    .item_o (f_item)
  );

  matf_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push_i),
    .item_i  (f_item),
    .full_o  (full_o),
    .pop_i   (q_pop),
    .empty_o (q_empty),
    .item_o  (q_item)
  );

  matf_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg),
    .q_empty_i  (q_empty),
    .q_item_i   (q_item),
    .q_pop_o    (q_pop),
    .pop_i      (pop_i),
    .empty_o    (empty_o),
    .out_o      (res),
    .new_prev_o (np),
    .dec_o      (dec)
  );

  assign out_red_o        = res[0];
  assign out_green_o      = res[1];
  assign out_blue_o       = res[2];
  assign new_prev_red_o   = np[0];
  assign new_prev_green_o = np[1];
  assign new_prev_blue_o  = np[2];
  assign decision_o       = dec;

endmodule
